@@ design/dgcd_pkg.sv @@
// Package: shared types, constants and the microcode table of the cycle detector.
package dgcd_pkg;

  localparam int ROWS  = 64;
  localparam int VTX_W = 6;
  localparam int IDX_W = 7;
  localparam int STK_W = VTX_W + IDX_W;

  typedef struct packed {
    logic             cmd;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
  } in_t;

  typedef struct packed {
    logic has_cycle;
    logic bad_edge;
  } out_t;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_ROOT,
    S_SCAN,
    S_POP,
    S_DONE
  } step_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ADD,
    OP_ROOT,
    OP_SCAN,
    OP_POP,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] br;
  } status_t;

  typedef struct packed {
    op_t   op;
    step_t tgt0;
    step_t tgt1;
    step_t tgt2;
    step_t tgt3;
  } uword_t;

  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] idx;
  } ffs_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_IDLE:  w = '{OP_IDLE, S_IDLE, S_ADD,  S_IDLE, S_ROOT};
      S_ADD:   w = '{OP_ADD,  S_IDLE, S_IDLE, S_IDLE, S_IDLE};
      S_ROOT:  w = '{OP_ROOT, S_SCAN, S_DONE, S_DONE, S_DONE};
      S_SCAN:  w = '{OP_SCAN, S_SCAN, S_DONE, S_ROOT, S_POP};
      S_POP:   w = '{OP_POP,  S_SCAN, S_SCAN, S_SCAN, S_SCAN};
      S_DONE:  w = '{OP_DONE, S_DONE, S_IDLE, S_IDLE, S_IDLE};
      default: w = '{OP_IDLE, S_IDLE, S_IDLE, S_IDLE, S_IDLE};
    endcase
    return w;
  endfunction

  function automatic ffs_t find_first(input logic [ROWS-1:0] x);
    logic [ROWS-1:0] low;
    ffs_t            r;
    low     = x & (~x + ROWS'(1));
    r.found = |x;
    r.idx   = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (low[i]) begin
        r.idx = r.idx | VTX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ design/dgcd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dgcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/dgcd_sequencer.sv @@
// Microcode sequencer: step counter, control store and branch selection.
module dgcd_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  dgcd_pkg::status_t status,
  output dgcd_pkg::ctrl_t   ctrl
);

  dgcd_pkg::step_t  step;
  dgcd_pkg::step_t  step_next;
  dgcd_pkg::uword_t uw;

  assign uw = dgcd_pkg::ucode(step);

  always_comb begin
    case (status.br)
      2'd0:    step_next = uw.tgt0;
      2'd1:    step_next = uw.tgt1;
      2'd2:    step_next = uw.tgt2;
      2'd3:    step_next = uw.tgt3;
      default: step_next = uw.tgt0;
    endcase
  end

  always_comb begin
    ctrl.op = uw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dgcd_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ design/dgcd_datapath.sv @@
// Datapath: adjacency store, walk stack, marks, neighbor search and result register.
module dgcd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dgcd_pkg::ctrl_t                   ctrl,
  output dgcd_pkg::status_t                 status,
  input  logic [dgcd_pkg::IDX_W-1:0]        vcount,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dgcd_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dgcd_pkg::out_t                    out_data
);

  localparam int ROWS  = dgcd_pkg::ROWS;
  localparam int VTX_W = dgcd_pkg::VTX_W;
  localparam int IDX_W = dgcd_pkg::IDX_W;
  localparam int STK_W = dgcd_pkg::STK_W;

  logic [ROWS-1:0]  visited, visited_next;
  logic [ROWS-1:0]  onpath, onpath_next;
  logic [ROWS-1:0]  row_valid, row_valid_next;
  logic [IDX_W-1:0] depth, depth_next;
  logic [VTX_W-1:0] cur_v, cur_v_next;
  logic [IDX_W-1:0] cur_idx, cur_idx_next;
  logic [VTX_W-1:0] e_src, e_src_next;
  logic [VTX_W-1:0] e_dst, e_dst_next;
  logic             cyc, cyc_next;
  logic             bad_seen, bad_seen_next;
  logic             rv_q;
  logic             out_valid_next;
  dgcd_pkg::out_t   out_data_next;

  logic             adj_we, adj_re;
  logic [VTX_W-1:0] adj_waddr, adj_raddr;
  logic [ROWS-1:0]  adj_wdata, adj_rdata;
  logic             stk_we, stk_re;
  logic [VTX_W-1:0] stk_waddr, stk_raddr;
  logic [STK_W-1:0] stk_wdata, stk_rdata;

  logic [ROWS-1:0]  row;
  logic [ROWS-1:0]  cand;
  dgcd_pkg::ffs_t   fs;
  dgcd_pkg::ffs_t   root_fs;
  logic [IDX_W-1:0] j_next_idx;
  logic [IDX_W-1:0] depth_m1;
  logic             edge_bad;

  dgcd_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dgcd_ram #(.WIDTH(STK_W), .DEPTH(ROWS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign row        = rv_q ? adj_rdata : '0;
  assign cand       = row & ({ROWS{1'b1}} << cur_idx);
  assign fs         = dgcd_pkg::find_first(cand);
  assign root_fs    = dgcd_pkg::find_first(~visited);
  assign j_next_idx = {1'b0, fs.idx} + IDX_W'(1);
  assign depth_m1   = depth - IDX_W'(1);
  assign edge_bad   = ({1'b0, in_data.src_vertex} >= vcount) ||
                      ({1'b0, in_data.dst_vertex} >= vcount);
  assign in_stall   = (ctrl.op != dgcd_pkg::OP_IDLE);

  always_comb begin
    status.br      = 2'd0;
    visited_next   = visited;
    onpath_next    = onpath;
    row_valid_next = row_valid;
    depth_next     = depth;
    cur_v_next     = cur_v;
    cur_idx_next   = cur_idx;
    e_src_next     = e_src;
    e_dst_next     = e_dst;
    cyc_next       = cyc;
    bad_seen_next  = bad_seen;
    out_valid_next = out_valid & out_stall;
    out_data_next  = out_data;
    adj_we         = 1'b0;
    adj_waddr      = e_src;
    adj_wdata      = row | (ROWS'(1) << e_dst);
    adj_re         = 1'b0;
    adj_raddr      = in_data.src_vertex;
    stk_we         = 1'b0;
    stk_waddr      = depth[VTX_W-1:0];
    stk_wdata      = {j_next_idx, cur_v};
    stk_re         = 1'b0;
    stk_raddr      = depth_m1[VTX_W-1:0];
    case (ctrl.op)
      dgcd_pkg::OP_IDLE: begin
        if (in_valid) begin
          e_src_next = in_data.src_vertex;
          e_dst_next = in_data.dst_vertex;
          if (in_data.cmd == dgcd_pkg::CMD_EVAL) begin
            status.br = 2'd3;
          end else if (edge_bad) begin
            bad_seen_next = 1'b1;
            status.br     = 2'd2;
          end else begin
            adj_re    = 1'b1;
            status.br = 2'd1;
          end
        end
      end
      dgcd_pkg::OP_ADD: begin
        adj_we                = 1'b1;
        row_valid_next[e_src] = 1'b1;
      end
      dgcd_pkg::OP_ROOT: begin
        if (root_fs.found) begin
          cur_v_next                = root_fs.idx;
          cur_idx_next              = '0;
          visited_next[root_fs.idx] = 1'b1;
          onpath_next[root_fs.idx]  = 1'b1;
          adj_re                    = 1'b1;
          adj_raddr                 = root_fs.idx;
        end else begin
          status.br = 2'd1;
        end
      end
      dgcd_pkg::OP_SCAN: begin
        if (!fs.found) begin
          onpath_next[cur_v] = 1'b0;
          if (depth == '0) begin
            status.br = 2'd2;
          end else begin
            stk_re     = 1'b1;
            depth_next = depth_m1;
            status.br  = 2'd3;
          end
        end else if (onpath[fs.idx]) begin
          cyc_next  = 1'b1;
          status.br = 2'd1;
        end else if (visited[fs.idx]) begin
          cur_idx_next = j_next_idx;
        end else begin
          stk_we               = 1'b1;
          depth_next           = depth + IDX_W'(1);
          cur_v_next           = fs.idx;
          cur_idx_next         = '0;
          visited_next[fs.idx] = 1'b1;
          onpath_next[fs.idx]  = 1'b1;
          adj_re               = 1'b1;
          adj_raddr            = fs.idx;
        end
      end
      dgcd_pkg::OP_POP: begin
        cur_v_next   = stk_rdata[VTX_W-1:0];
        cur_idx_next = stk_rdata[STK_W-1:VTX_W];
        adj_re       = 1'b1;
        adj_raddr    = stk_rdata[VTX_W-1:0];
      end
      dgcd_pkg::OP_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next          = 1'b1;
          out_data_next.has_cycle = cyc;
          out_data_next.bad_edge  = bad_seen;
          visited_next            = '0;
          onpath_next             = '0;
          row_valid_next          = '0;
          depth_next              = '0;
          cyc_next                = 1'b0;
          bad_seen_next           = 1'b0;
          status.br               = 2'd1;
        end
      end
      default: begin
        status.br = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited   <= '0;
      onpath    <= '0;
      row_valid <= '0;
      depth     <= '0;
      cyc       <= 1'b0;
      bad_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      visited   <= visited_next;
      onpath    <= onpath_next;
      row_valid <= row_valid_next;
      depth     <= depth_next;
      cyc       <= cyc_next;
      bad_seen  <= bad_seen_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_v    <= cur_v_next;
    cur_idx  <= cur_idx_next;
    e_src    <= e_src_next;
    e_dst    <= e_dst_next;
    out_data <= out_data_next;
    if (adj_re) begin
      rv_q <= row_valid[adj_raddr];
    end
  end

endmodule

@@ design/directed_graph_cycle_detect_top.sv @@
// Top level: vertex count register and the microcoded cycle detector.
//
// Directed graph cycle detector. Each add transaction stores one edge into a 64-row
// adjacency RAM by a row read and then a row write-back; an edge naming a vertex at
// or beyond the vertex count is dropped and reported through bad_edge. An evaluate
// transaction runs a depth-first walk from every vertex under a microcode sequencer
// and returns one result transaction: it picks a root per tree plus a final pick,
// scans each edge and each finished vertex, reads the stack on each return to a
// parent and then loads the result. Input stalls for the whole walk, a cycle found
// cuts the walk short, and a result still waiting in the output register holds the
// load step. After the result is loaded the graph is empty again.
module directed_graph_cycle_detect_top #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dgcd_pkg::IDX_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dgcd_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dgcd_pkg::out_t             out_data
);

  localparam int                       CAP_INT = (MAX_VERTICES < dgcd_pkg::ROWS) ?
                                                 MAX_VERTICES : dgcd_pkg::ROWS;
  localparam logic [dgcd_pkg::IDX_W-1:0] VCAP = dgcd_pkg::IDX_W'(CAP_INT);
  localparam logic [dgcd_pkg::IDX_W-1:0] VRESET = dgcd_pkg::IDX_W'(dgcd_pkg::ROWS);

  logic [dgcd_pkg::IDX_W-1:0] vertex_count;
  logic [dgcd_pkg::IDX_W-1:0] vcount;
  dgcd_pkg::ctrl_t            ctrl;
  dgcd_pkg::status_t          status;

  assign vcount = (vertex_count > VCAP) ? VCAP : vertex_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VRESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  dgcd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  dgcd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .vcount    (vcount),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ bench/directed_graph_cycle_detect_checker.sv @@
// Checker: tracks the loaded graph, predicts each evaluate result and compares.
`timescale 1ns / 1ps
module directed_graph_cycle_detect_checker #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [dgcd_pkg::IDX_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  dgcd_pkg::in_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  dgcd_pkg::out_t             out_data,
  output int                         failures,
  output int                         pending
);

  logic [dgcd_pkg::ROWS-1:0]  edge_rows [dgcd_pkg::ROWS];
  logic                       dropped_edge;
  logic [dgcd_pkg::IDX_W-1:0] vertex_count;
  dgcd_pkg::out_t             verdicts [$];

  function automatic int usable_count();
    int n;
    n = int'(vertex_count);
    if (n > MAX_VERTICES) n = MAX_VERTICES;
    if (n > dgcd_pkg::ROWS) n = dgcd_pkg::ROWS;
    return n;
  endfunction

  // peel off vertices with no successor left; whatever survives lies on or leads into a cycle
  function automatic logic graph_has_loop();
    logic [dgcd_pkg::ROWS-1:0] alive;
    logic                      changed;
    alive   = '1;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int v = 0; v < dgcd_pkg::ROWS; v++) begin
        if (alive[v] && (edge_rows[v] & alive) == '0) begin
          alive[v] = 1'b0;
          changed  = 1'b1;
        end
      end
    end
    return |alive;
  endfunction

  function automatic void clear_graph();
    for (int v = 0; v < dgcd_pkg::ROWS; v++) edge_rows[v] = '0;
    dropped_edge = 1'b0;
  endfunction

  task automatic report(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    failures++;
  endtask

  always @(posedge clk) begin
    dgcd_pkg::out_t want;
    int             n;
    if (rst) begin
      clear_graph();
      vertex_count = dgcd_pkg::IDX_W'(64);
      verdicts.delete();
      failures = 0;
    end else begin
      if (cfg_we) vertex_count = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_data.cmd == dgcd_pkg::CMD_ADD) begin
          n = usable_count();
          if (int'(in_data.src_vertex) >= n || int'(in_data.dst_vertex) >= n)
            dropped_edge = 1'b1;
          else
            edge_rows[in_data.src_vertex][in_data.dst_vertex] = 1'b1;
        end else begin
          want.has_cycle = graph_has_loop();
          want.bad_edge  = dropped_edge;
          verdicts.insert(verdicts.size(), want);
          clear_graph();
        end
      end
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          report($sformatf("result transaction with none outstanding: has_cycle %0b bad_edge %0b",
                           out_data.has_cycle, out_data.bad_edge));
        end else begin
          want = verdicts.pop_front();
          if (out_data.has_cycle !== want.has_cycle)
            report($sformatf("has_cycle %0b, predicted %0b", out_data.has_cycle,
                             want.has_cycle));
          if (out_data.bad_edge !== want.bad_edge)
            report($sformatf("bad_edge %0b, predicted %0b", out_data.bad_edge,
                             want.bad_edge));
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

@@ bench/directed_graph_cycle_detect_top_test.sv @@
// Testbench top: clock, reset, edge and evaluate stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module directed_graph_cycle_detect_top_test;

  localparam int VERTS     = 64;
  localparam int ITEMS     = 2000;
  localparam int HOLD_LEN  = 600;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [dgcd_pkg::IDX_W-1:0] cfg_wdata = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  dgcd_pkg::in_t              in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  dgcd_pkg::out_t             out_data;

  int   failures;
  int   pending;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  logic hold_go    = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;
  int   sent       = 0;
  int   eff_count  = VERTS;
  int   idle_plan [4] = '{0, 56, 0, 11};
  int   stall_plan [4] = '{0, 0, 56, 11};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  directed_graph_cycle_detect_top #(
    .MAX_VERTICES(VERTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  directed_graph_cycle_detect_checker #(
    .MAX_VERTICES(VERTS)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .failures (failures),
    .pending  (pending)
  );

  always @(negedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_left  = HOLD_LEN;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_transaction(input logic cmd, input int s, input int d);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{cmd: cmd, src_vertex: dgcd_pkg::VTX_W'(s),
                  dst_vertex: dgcd_pkg::VTX_W'(d)};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic add_edge(input int s, input int d);
    send_transaction(dgcd_pkg::CMD_ADD, s, d);
  endtask

  task automatic run_eval();
    send_transaction(dgcd_pkg::CMD_EVAL, $urandom_range(63), $urandom_range(63));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_count(input int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= dgcd_pkg::IDX_W'(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    eff_count = (v > VERTS) ? VERTS : v;
  endtask

  // ranks map to vertices through a rotation, so ascending ranks stay acyclic
  task automatic load_graph(input int eff);
    int m, off, kind, count, ring, a, b, t;
    m     = (eff < 1) ? 1 : eff;
    off   = $urandom_range(m - 1);
    kind  = $urandom_range(4);
    count = $urandom_range((m < 8) ? 4 : 20);
    if (kind == 2) begin
      ring = $urandom_range(m, 1);
      for (int i = 0; i < ring; i++) add_edge((i + off) % m, ((i + 1) % ring + off) % m);
    end
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(m - 1);
      b = $urandom_range(m - 1);
      if (kind == 4) begin
        add_edge($urandom_range(63), $urandom_range(63));
      end else if (kind == 3) begin
        add_edge((a + off) % m, (b + off) % m);
      end else begin
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        if (kind == 1 && $urandom_range(7) == 0) begin
          t = a;
          a = b;
          b = t;
        end
        if (a != b) add_edge((a + off) % m, (b + off) % m);
      end
    end
    if ($urandom_range(7) == 0) add_edge($urandom_range(63), $urandom_range(63));
  endtask

  initial begin
    int g, phase;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_eval();
    add_edge(0, 63);
    add_edge(63, 0);
    run_eval();
    add_edge(5, 5);
    run_eval();
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 3);
    add_edge(0, 3);
    run_eval();
    set_count(0);
    add_edge(0, 0);
    run_eval();
    set_count(1);
    add_edge(0, 0);
    add_edge(1, 0);
    run_eval();
    set_count(127);
    add_edge(63, 62);
    add_edge(62, 63);
    run_eval();
    set_count(64);
    add_edge(40, 41);
    add_edge(41, 40);
    set_count(8);
    add_edge(9, 1);
    add_edge(3, 4);
    run_eval();

    g = 0;
    while (sent < ITEMS) begin
      if (g % 15 == 0) begin
        phase     = (g / 15) % 4;
        idle_pct  = idle_plan[phase];
        stall_pct <= stall_plan[phase];
      end
      if (g == 40) hold_go <= 1'b1;
      if ($urandom_range(11) == 0) begin
        case ($urandom_range(7))
          0:       set_count(0);
          1:       set_count(1);
          2:       set_count(127);
          3:       set_count(65);
          4:       set_count(64);
          default: set_count($urandom_range(VERTS, 2));
        endcase
      end
      load_graph(eff_count);
      run_eval();
      g++;
    end

    drain();
    repeat (50) @(negedge clk);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
